// File: rtl/core/msbbr_pkg.sv
// msbbr_pkg: shared types, sizes and command codes for the msb-first bit reader
// used by msbbr_ctrl, msbbr_dp and msb_first_bit_reader; no dependencies
`default_nettype none

package msbbr_pkg;

  // buffer geometry
  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CNT_W     = ADDR_W + 1;            // holds 0..BUF_BYTES
  localparam int POS_W     = CNT_W + 3;             // bit position 0..8*BUF_BYTES
  localparam int IDX_W     = CNT_W + 1;             // byte index incl. look-ahead
  localparam int SKIP_W    = (POS_W > 16) ? POS_W : 16;

  // get window: up to 32 bits span at most five bytes
  localparam int MAX_GET   = 32;
  localparam int GET_BYTES = 5;
  localparam int STEP_W    = $clog2(GET_BYTES);

  // command codes
  localparam logic [2:0] CMD_LOAD    = 3'd0;
  localparam logic [2:0] CMD_GET     = 3'd1;
  localparam logic [2:0] CMD_SKIP    = 3'd2;
  localparam logic [2:0] CMD_MARK    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  byte_in;
    logic [5:0]  get_width;
    logic [15:0] skip_count;
  } req_t;

  typedef struct packed {
    logic [31:0] bits_value;
    logic [15:0] bits_skipped;
    logic [15:0] bits_used;
    logic        short_read;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic run_simple;   // execute a non-get request at accept
    logic get_load;     // latch get parameters at accept
    logic rd_issue;     // read next byte of the get window
    logic rd_capture;   // shift the previous read byte into the window
    logic get_finish;   // assemble get result and update position
  } dp_cmd_t;

endpackage : msbbr_pkg

`default_nettype wire

// File: rtl/core/msb_first_bit_reader.sv
// msb_first_bit_reader: top level of the msb-first bitstream reader
// every request gives its registered result strobe in the cycle after the one it ends in
// load, skip, mark, restart: accepted every cycle while not busy, result strobe in the next cycle
// get: busy through five reads of the single byte store port and one assembly;
//   no new request is accepted while busy
// reset: asynchronous, buffer empty, position and mark zero; receiver cannot stall
`default_nettype none

module msb_first_bit_reader
  import msbbr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  dp_cmd_t dp_cmd;

  // sequencing
  msbbr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (req_i.cmd),
    .busy     (busy),
    .dp_cmd_o (dp_cmd)
  );

  // storage and arithmetic
  msbbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .dp_cmd_i    (dp_cmd),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule : msb_first_bit_reader

`default_nettype wire

// File: rtl/core/msbbr_ctrl.sv
// msbbr_ctrl: request handshake and get sequencing state machine
// depends on msbbr_pkg
`default_nettype none

module msbbr_ctrl
  import msbbr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [2:0] cmd_i,
  output logic       busy,
  output dp_cmd_t    dp_cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              accept;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_GET) begin
          state_d = ST_READ;
          step_d  = '0;
        end
      end
      ST_READ: begin
        if (step_q == STEP_W'(GET_BYTES - 1)) begin
          state_d = ST_FIN;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // datapath commands
  always_comb begin
    dp_cmd_o.run_simple = accept && (cmd_i != CMD_GET);
    dp_cmd_o.get_load   = accept && (cmd_i == CMD_GET);
    dp_cmd_o.rd_issue   = (state_q == ST_READ);
    dp_cmd_o.rd_capture = (state_q == ST_READ) && (step_q != '0);
    dp_cmd_o.get_finish = (state_q == ST_FIN);
  end

endmodule : msbbr_ctrl

`default_nettype wire

// File: rtl/core/msbbr_dp.sv
// msbbr_dp: byte store, position registers, get window and result register
// depends on msbbr_pkg; driven by msbbr_ctrl commands
`default_nettype none

module msbbr_dp
  import msbbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  dp_cmd_t dp_cmd_i,
  output logic    rsp_valid_o,
  output rsp_t    rsp_o
);

  logic [7:0] mem [BUF_BYTES];

  logic [CNT_W-1:0] loaded_q, loaded_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] mark_q, mark_d;
  logic [IDX_W-1:0] addr_q;
  logic [2:0]       off_q;
  logic [5:0]       width_q;
  logic [31:0]      win_q;
  logic [7:0]       rd_data_q;
  logic             rd_ok_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;

  logic [POS_W-1:0]  end_bit;
  logic [7:0]        byte_m;
  logic [39:0]       win_full;
  logic [39:0]       win_sh;
  logic [31:0]       get_value;
  logic [POS_W:0]    get_sum;
  logic [POS_W-1:0]  avail;
  logic [SKIP_W-1:0] skipped;
  logic [POS_W-1:0]  used;
  logic              load_ok;
  logic [5:0]        width_sat;

  assign end_bit   = {loaded_q, 3'b000};
  assign byte_m    = rd_ok_q ? rd_data_q : 8'd0;
  assign load_ok   = (loaded_q < CNT_W'(BUF_BYTES));
  assign width_sat = (req_i.get_width > 6'(MAX_GET)) ? 6'(MAX_GET) : req_i.get_width;

  // byte store write on load and registered window read
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.run_simple && req_i.cmd == CMD_LOAD && load_ok) begin
      mem[loaded_q[ADDR_W-1:0]] <= req_i.byte_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.rd_issue) begin
      rd_data_q <= mem[addr_q[ADDR_W-1:0]];
    end
  end

  // get window assembly
  assign win_full  = {win_q, byte_m};
  assign win_sh    = win_full << off_q;
  assign get_value = win_sh[39:8] >> (6'(MAX_GET) - width_q);
  assign get_sum   = {1'b0, pos_q} + (POS_W + 1)'(width_q);

  // skip clamp
  assign avail   = (pos_q < end_bit) ? (end_bit - pos_q) : '0;
  assign skipped = (SKIP_W'(req_i.skip_count) < SKIP_W'(avail))
                   ? SKIP_W'(req_i.skip_count) : SKIP_W'(avail);

  // next architectural state and result
  always_comb begin
    loaded_d = loaded_q;
    pos_d    = pos_q;
    mark_d   = mark_q;
    rsp_d    = '0;
    if (dp_cmd_i.run_simple) begin
      unique case (req_i.cmd)
        CMD_LOAD: begin
          if (load_ok) begin
            loaded_d = loaded_q + CNT_W'(1);
          end
        end
        CMD_SKIP: begin
          pos_d              = pos_q + POS_W'(skipped);
          rsp_d.bits_skipped = skipped[15:0];
        end
        CMD_MARK: begin
          mark_d = pos_q;
        end
        CMD_RESTART: begin
          loaded_d = '0;
          pos_d    = '0;
          mark_d   = '0;
        end
        default: begin
        end
      endcase
    end else if (dp_cmd_i.get_finish) begin
      rsp_d.bits_value = (width_q == 6'd0) ? 32'd0 : get_value;
      if (get_sum > {1'b0, end_bit}) begin
        pos_d            = end_bit;
        rsp_d.short_read = (width_q != 6'd0);
      end else begin
        pos_d = get_sum[POS_W-1:0];
      end
    end
    used            = (pos_d >= mark_d) ? (pos_d - mark_d) : '0;
    rsp_d.bits_used = used[15:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      pos_q       <= '0;
      mark_q      <= '0;
      rsp_valid_q <= 1'b0;
      addr_q      <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      loaded_q    <= loaded_d;
      pos_q       <= pos_d;
      mark_q      <= mark_d;
      rsp_valid_q <= dp_cmd_i.run_simple || dp_cmd_i.get_finish;
      if (dp_cmd_i.get_load) begin
        addr_q <= IDX_W'(pos_q[POS_W-1:3]);
      end else if (dp_cmd_i.rd_issue) begin
        addr_q <= addr_q + IDX_W'(1);
      end
      if (dp_cmd_i.rd_issue) begin
        rd_ok_q <= (addr_q < IDX_W'(loaded_q));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.get_load) begin
      off_q   <= pos_q[2:0];
      width_q <= width_sat;
      win_q   <= '0;
    end else if (dp_cmd_i.rd_capture) begin
      win_q <= {win_q[23:0], byte_m};
    end
    if (dp_cmd_i.run_simple || dp_cmd_i.get_finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule : msbbr_dp

`default_nettype wire

// File: sim/bit_reader_check_pkg.sv
// bit_reader_check_pkg: scoreboard for the msb-first bit reader test, holding its own
// copy of buffer, position and mark and a queue of predicted results
// depends on msbbr_pkg for request/result types, command codes and buffer size
`timescale 1ns / 100ps

package bit_reader_check_pkg;
  import msbbr_pkg::*;

  class bit_reader_scoreboard;
    logic [7:0]  shadow_bytes [BUF_BYTES];
    int unsigned shadow_loaded;
    int unsigned shadow_pos;
    int unsigned shadow_mark;
    rsp_t        pending_rsp [$];
    int          failures;

    function new();
      shadow_loaded = 0;
      shadow_pos    = 0;
      shadow_mark   = 0;
      failures      = 0;
    endfunction

    // one bit of the stream, msb of each byte first; zero past the data
    function bit stream_bit(int unsigned pos);
      int unsigned idx;
      idx = pos >> 3;
      if (idx >= shadow_loaded) return 1'b0;
      return shadow_bytes[idx][7 - (pos & 7)];
    endfunction

    // apply an accepted request to the shadow state and queue its result
    function void note_request(req_t req);
      rsp_t        exp_rsp;
      int unsigned end_bit;
      int unsigned width;
      int unsigned advance;
      int unsigned used;
      exp_rsp = '0;
      end_bit = shadow_loaded * 8;
      case (req.cmd)
        CMD_LOAD: begin
          if (shadow_loaded < BUF_BYTES) begin
            shadow_bytes[shadow_loaded] = req.byte_in;
            shadow_loaded++;
          end
        end
        CMD_GET: begin
          // widths above the window saturate
          width = (req.get_width > MAX_GET) ? MAX_GET : req.get_width;
          for (int unsigned i = 0; i < width; i++)
            exp_rsp.bits_value = {exp_rsp.bits_value[30:0], stream_bit(shadow_pos + i)};
          if (shadow_pos + width > end_bit) begin
            exp_rsp.short_read = (width > 0);
            shadow_pos = end_bit;
          end else begin
            shadow_pos += width;
          end
        end
        CMD_SKIP: begin
          // clamp at the end of the loaded data
          advance = (shadow_pos < end_bit) ? end_bit - shadow_pos : 0;
          if (req.skip_count < advance) advance = req.skip_count;
          shadow_pos += advance;
          exp_rsp.bits_skipped = advance[15:0];
        end
        CMD_MARK: begin
          shadow_mark = shadow_pos;
        end
        CMD_RESTART: begin
          shadow_loaded = 0;
          shadow_pos    = 0;
          shadow_mark   = 0;
        end
        default: ;
      endcase
      used = (shadow_pos >= shadow_mark) ? shadow_pos - shadow_mark : 0;
      exp_rsp.bits_used = used[15:0];
      pending_rsp.push_back(exp_rsp);
    endfunction

    // compare a result strobe with the oldest prediction
    function void check_response(rsp_t got);
      rsp_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $error("result strobe with no request pending");
        failures++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.bits_value !== exp_rsp.bits_value) begin
        $error("bits_value: expected %h, got %h", exp_rsp.bits_value, got.bits_value);
        failures++;
      end
      if (got.bits_skipped !== exp_rsp.bits_skipped) begin
        $error("bits_skipped: expected %0d, got %0d", exp_rsp.bits_skipped,
               got.bits_skipped);
        failures++;
      end
      if (got.bits_used !== exp_rsp.bits_used) begin
        $error("bits_used: expected %0d, got %0d", exp_rsp.bits_used, got.bits_used);
        failures++;
      end
      if (got.short_read !== exp_rsp.short_read) begin
        $error("short_read: expected %b, got %b", exp_rsp.short_read, got.short_read);
        failures++;
      end
    endfunction
  endclass

endpackage : bit_reader_check_pkg

// File: sim/msb_first_bit_reader_test.sv
// msb_first_bit_reader_test: drives load, get, skip, mark and restart requests into
// the msb-first bit reader and checks every result against bit_reader_scoreboard
// depends on msbbr_pkg and bit_reader_check_pkg
`timescale 1ns / 100ps

module msb_first_bit_reader_test;
  import msbbr_pkg::*;
  import bit_reader_check_pkg::*;

  // codes above restart do nothing but report bits_used
  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam int         RANDOM_REQUESTS  = 600;
  localparam int         QUIET_TAIL       = 100;
  localparam int         FILL_BYTES       = 48;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  req_t req_i  = '0;
  logic rsp_valid_o;
  rsp_t rsp_o;

  bit_reader_scoreboard sb = new();
  bit idling_on = 1'b0;
  int requests_sent = 0;

  msb_first_bit_reader uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  // 250 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // result check first, then note a request accepted at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o === 1'b1) begin
        sb.check_response(rsp_o);
      end else if (rsp_valid_o !== 1'b0) begin
        $error("rsp_valid_o: expected 0 or 1, got %b", rsp_valid_o);
        sb.failures++;
      end
      if (start && busy === 1'b0) sb.note_request(req_i);
    end
  end

  // request with random filler in the fields the command does not use
  function automatic req_t make_req(logic [2:0] op, int unsigned arg);
    req_t        req;
    logic [31:0] noise;
    noise          = $urandom;
    req.byte_in    = noise[7:0];
    req.get_width  = noise[13:8];
    noise          = $urandom;
    req.skip_count = noise[15:0];
    req.cmd        = op;
    case (op)
      CMD_LOAD: req.byte_in    = arg[7:0];
      CMD_GET:  req.get_width  = arg[5:0];
      CMD_SKIP: req.skip_count = arg[15:0];
      default: ;
    endcase
    return req;
  endfunction

  // hold the request until accepted, then maybe leave a gap
  task automatic send_request(input req_t req);
    start <= 1'b1;
    req_i <= req;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (req.cmd <= CMD_RESTART) requests_sent++;
    if (idling_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      req_i <= make_req(3'($urandom_range(0, 7)), $urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  initial begin
    int base;
    int nload;
    int nops;
    int pick;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short fill, idling only over its first half
    for (int i = 0; i < FILL_BYTES; i++) begin
      idling_on = (i < FILL_BYTES / 2);
      send_request(make_req(CMD_LOAD, $urandom));
    end
    idling_on = 1'b1;

    // loads after the fill, long skip clamps at the end, reads past it
    repeat (3) send_request(make_req(CMD_LOAD, $urandom));
    send_request(make_req(CMD_GET, 32));
    send_request(make_req(CMD_SKIP, 16'hFFFF));
    send_request(make_req(CMD_GET, 8));
    send_request(make_req(CMD_MARK, 0));
    send_request(make_req(CMD_GET, 1));
    send_request(make_req(CMD_RESTART, 0));

    // directed: field extremes, saturated width, reads past the end
    send_request(make_req(CMD_LOAD, 8'h00));
    send_request(make_req(CMD_LOAD, 8'hFF));
    send_request(make_req(CMD_LOAD, 8'hA5));
    send_request(make_req(CMD_LOAD, 8'h5A));
    send_request(make_req(CMD_GET, 0));
    send_request(make_req(CMD_GET, 1));
    send_request(make_req(CMD_GET, 13));
    send_request(make_req(CMD_GET, 63));
    send_request(make_req(CMD_SKIP, 10));
    send_request(make_req(CMD_LOAD, 8'h80));
    send_request(make_req(CMD_GET, 1));
    send_request(make_req(CMD_MARK, 0));
    send_request(make_req(CMD_SKIP, 16'hFFFF));
    send_request(make_req(CMD_GET, 4));
    send_request(make_req(CMD_LOAD, 8'hC3));
    send_request(make_req(CMD_GET, 8));
    send_request(make_req(CMD_FIRST_UNUSED, 0));
    send_request(make_req(CMD_FIRST_UNUSED + 3'd1, 0));
    send_request(make_req(CMD_FIRST_UNUSED + 3'd2, 0));
    send_request(make_req(CMD_MARK, 0));
    send_request(make_req(CMD_RESTART, 0));
    send_request(make_req(CMD_GET, 32));
    send_request(make_req(CMD_SKIP, 5));

    // random: mostly restart, load a buffer (usually short), then a mix of requests
    base = requests_sent;
    while (requests_sent - base < RANDOM_REQUESTS) begin
      if (requests_sent - base < RANDOM_REQUESTS - QUIET_TAIL)
        idling_on = ($urandom_range(0, 3) != 0);
      else
        idling_on = 1'b0;
      if ($urandom_range(0, 4) != 0) send_request(make_req(CMD_RESTART, 0));
      nload = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 300) : $urandom_range(1, 24);
      repeat (nload) send_request(make_req(CMD_LOAD, $urandom));
      nops = $urandom_range(4, 30);
      repeat (nops) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)
          send_request(make_req(CMD_GET, ($urandom_range(0, 5) == 0) ?
                                         $urandom_range(0, 63) : $urandom_range(1, 32)));
        else if (pick < 55)
          send_request(make_req(CMD_SKIP, ($urandom_range(0, 4) == 0) ?
                                          $urandom_range(0, 65535) : $urandom_range(0, 48)));
        else if (pick < 67)
          send_request(make_req(CMD_MARK, 0));
        else if (pick < 82)
          send_request(make_req(CMD_LOAD, $urandom));
        else if (pick < 88)
          send_request(make_req(CMD_FIRST_UNUSED + 3'($urandom_range(0, 2)), 0));
        else if (pick < 92)
          send_request(make_req(CMD_RESTART, 0));
        else
          send_request(make_req(CMD_GET, ($urandom_range(0, 1) == 0) ?
                                         0 : $urandom_range(33, 63)));
      end
    end
    start <= 1'b0;

    // drain outstanding results, then wait quietly before the final check
    for (int n = 0; n < 200 && sb.pending_rsp.size() != 0; n++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.pending_rsp.size() != 0)
      $error("results missing: %0d requests never answered", sb.pending_rsp.size());

    if (sb.failures == 0 && sb.pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : msb_first_bit_reader_test
